>>> hdl/csa_pkg.sv
package csa_pkg;

    localparam int SLOTS_DEF = 320;
    localparam int FW = 9;
    localparam int RCW = 8;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_LAST  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    typedef struct packed {
        logic clear_step;
        logic start;
        logic check_step;
        logic update_step;
        logic rewind;
        logic scan_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_slot;
        logic range_ok;
        logic conflict;
    } sts_t;

endpackage

>>> hdl/contiguous_slot_allocator.sv
// Contiguous slot allocator over a busy bitmap of SLOTS slots held in a one-bit memory.
// After reset the block clears the bitmap, holding s_axis_tready low while it does so.
// Each transaction on s_axis is a search, mark-busy or free command (code 3 is unused) and yields
// exactly one result on m_axis. The datapath walks the bitmap one slot per cycle: a mark
// or free of L slots first checks the range and then writes it (the write is skipped
// when the check finds a conflict), then every command scans all SLOTS+1 positions.
// No new transaction is accepted until the result of the last one is registered, and
// that result waits while the previous result is still held on m_axis. fit_policy is
// written through cfg only while the block is idle.
module contiguous_slot_allocator
#(
    parameter int SLOTS = csa_pkg::SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // fit_policy [1:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // command, slot_start, slot_end, request_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status, found_start, found_end, free_slots,
                                       // largest_run, run_count
);

    logic          idle, in_fire;
    logic [1:0]    pol_reg;
    logic          ovalid_reg;
    logic [45:0]   odata_reg;
    csa_pkg::cmd_t cmd;
    csa_pkg::sts_t sts;
    logic [1:0]    status;
    logic [8:0]    fs, fe, fr, lr;
    logic [7:0]    rc;

    assign cfg_ready = idle;
    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {2'b00, odata_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= csa_pkg::POL_FIRST;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pol_reg <= cfg_data[1:0];
            if (cmd.finish)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            odata_reg <= {rc, lr, fr, fe, fs, status};
    end

    csa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .command  (s_axis_tdata[1:0]),
        .out_busy (ovalid_reg && !m_axis_tready),
        .sts      (sts),
        .idle     (idle),
        .cmd      (cmd)
    );

    csa_dp #(.SLOTS(SLOTS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .command      (s_axis_tdata[1:0]),
        .slot_start   (s_axis_tdata[10:2]),
        .slot_end     (s_axis_tdata[19:11]),
        .request_size (s_axis_tdata[28:20]),
        .fit_policy   (pol_reg),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .found_start  (fs),
        .found_end    (fe),
        .free_slots   (fr),
        .largest_run  (lr),
        .run_count    (rc)
    );

endmodule

>>> hdl/csa_ctrl.sv
module csa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [1:0]     command,
    input  logic           out_busy,
    input  csa_pkg::sts_t  sts,
    output logic           idle,
    output csa_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cmd_reg <= csa_pkg::CMD_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                cmd_reg <= command;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = (state_reg == S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.last_slot)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check_step = 1'b1;
                if ((cmd_reg != csa_pkg::CMD_MARK && cmd_reg != csa_pkg::CMD_FREE)
                    || !sts.range_ok)
                    state_next = S_SCAN;
                else if (sts.last_slot)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (sts.conflict)
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.update_step = 1'b1;
                    if (sts.last_slot)
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.last_slot)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> hdl/csa_dp.sv
module csa_dp
#(
    parameter int SLOTS = csa_pkg::SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_fire,
    input  logic [1:0]               command,
    input  logic [csa_pkg::FW-1:0]   slot_start,
    input  logic [csa_pkg::FW-1:0]   slot_end,
    input  logic [csa_pkg::FW-1:0]   request_size,
    input  logic [1:0]               fit_policy,
    input  csa_pkg::cmd_t            cmd,
    output csa_pkg::sts_t            sts,
    output logic [1:0]               status,
    output logic [csa_pkg::FW-1:0]   found_start,
    output logic [csa_pkg::FW-1:0]   found_end,
    output logic [csa_pkg::FW-1:0]   free_slots,
    output logic [csa_pkg::FW-1:0]   largest_run,
    output logic [csa_pkg::RCW-1:0]  run_count
);

    localparam int IW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = IW + 1;

    logic             slot_busy_reg [SLOTS];
    logic             rd_busy_reg;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [1:0]       c_reg;
    logic [csa_pkg::FW-1:0] lo_reg, hi_reg, need_reg;
    logic             conf_reg, have_reg;
    logic [CW-1:0]    free_reg, large_reg, runs_reg, rlen_reg, plen_reg;
    logic [CW-1:0]    rstart_reg, pick_reg;

    logic [IW-1:0] lo_i, hi_i;
    logic          is_rw, mem_we, mem_wdata;
    logic [AW-1:0] waddr, raddr;
    logic          cur_busy, at_end, fits, take;
    logic [CW-1:0] ext_need;

    assign lo_i = IW'(lo_reg);
    assign hi_i = IW'(hi_reg);
    assign ext_need = CW'(need_reg);
    assign is_rw = (c_reg == csa_pkg::CMD_MARK) || (c_reg == csa_pkg::CMD_FREE);
    assign sts.range_ok = (lo_reg <= hi_reg) && (32'(hi_reg) < 32'(SLOTS));
    assign sts.conflict = conf_reg;
    assign at_end = (idx_reg == IW'(SLOTS));
    assign cur_busy = at_end ? 1'b1 : rd_busy_reg;
    assign sts.last_slot = cmd.clear_step ? (idx_reg == IW'(SLOTS - 1))
                         : cmd.scan_step  ? at_end
                         : (idx_reg == hi_i);
    assign fits = (need_reg != '0) && (32'(rlen_reg) >= 32'(need_reg));

    always_comb
    begin
        take = 1'b0;
        case (fit_policy)
            csa_pkg::POL_FIRST: take = !have_reg;
            csa_pkg::POL_BEST:  take = !have_reg || rlen_reg < plen_reg;
            csa_pkg::POL_LAST:  take = 1'b1;
            default:            take = !have_reg || rlen_reg > plen_reg;
        endcase
    end

    // slot index for the next cycle, also the read address of the bitmap
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clear_step)
            idx_next = (idx_reg == IW'(SLOTS - 1)) ? '0 : idx_reg + IW'(1);
        else if (cmd.start)
            idx_next = IW'(slot_start);
        else if (cmd.check_step)
        begin
            if (!is_rw || !sts.range_ok)
                idx_next = '0;
            else
                idx_next = (idx_reg == hi_i) ? lo_i : idx_reg + IW'(1);
        end
        else if (cmd.update_step)
            idx_next = (idx_reg == hi_i) ? '0 : idx_reg + IW'(1);
        else if (cmd.rewind)
            idx_next = '0;
        else if (cmd.scan_step && !at_end)
            idx_next = idx_reg + IW'(1);
    end

    assign mem_we = cmd.clear_step || cmd.update_step;
    assign mem_wdata = cmd.update_step && (c_reg == csa_pkg::CMD_MARK);
    assign waddr = AW'(idx_reg);
    assign raddr = (32'(idx_next) < 32'(SLOTS)) ? AW'(idx_next) : '0;

    // busy bitmap, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_busy_reg[waddr] <= mem_wdata;
        rd_busy_reg <= (mem_we && waddr == raddr) ? mem_wdata : slot_busy_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            c_reg <= command;
            lo_reg <= slot_start;
            hi_reg <= slot_end;
            need_reg <= request_size;
        end
        if (cmd.start)
            conf_reg <= 1'b0;
        else if (cmd.check_step)
        begin
            if (!is_rw || !sts.range_ok)
                conf_reg <= 1'b1;
            else if (rd_busy_reg != (c_reg == csa_pkg::CMD_FREE))
                conf_reg <= 1'b1;
            free_reg <= '0; large_reg <= '0; runs_reg <= '0; rlen_reg <= '0;
            have_reg <= 1'b0; plen_reg <= '0; pick_reg <= '0; rstart_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!cur_busy)
            begin
                if (rlen_reg == '0)
                    rstart_reg <= CW'(idx_reg);
                rlen_reg <= rlen_reg + 1'b1;
                free_reg <= free_reg + 1'b1;
            end
            else if (rlen_reg != '0)
            begin
                runs_reg <= runs_reg + 1'b1;
                if (rlen_reg > large_reg)
                    large_reg <= rlen_reg;
                if (fits && take)
                begin
                    have_reg <= 1'b1;
                    plen_reg <= rlen_reg;
                    pick_reg <= (fit_policy == csa_pkg::POL_LAST)
                                ? rstart_reg + rlen_reg - ext_need : rstart_reg;
                end
                rlen_reg <= '0;
            end
        end
    end

    always_comb
    begin
        status = csa_pkg::ST_OK;
        found_start = '0;
        found_end = '0;
        if (c_reg == csa_pkg::CMD_SEARCH)
        begin
            if (!have_reg)
                status = csa_pkg::ST_NOFIT;
            else
            begin
                found_start = csa_pkg::FW'(pick_reg);
                found_end = csa_pkg::FW'(pick_reg + ext_need - 1'b1);
            end
        end
        else if (conf_reg)
            status = csa_pkg::ST_CONFLICT;
        free_slots = csa_pkg::FW'(free_reg);
        largest_run = csa_pkg::FW'(large_reg);
        run_count = csa_pkg::RCW'(runs_reg);
    end

endmodule
